// File: hdl/fjrq_pkg.sv
// ----------------------------------------------------------------------------
// fjrq_pkg
// Shared types and constants of the FIFO job run queue.
// ----------------------------------------------------------------------------
package fjrq_pkg;

    localparam int MaxJobsDefault = 16;
    localparam int IdBitsDefault  = 32;
    localparam int WordBits       = 32;
    localparam logic [WordBits-1:0] SliceReset = 32'd100;

    typedef enum logic [2:0] {
        REQ_ARRIVE   = 3'd0,
        REQ_COMPLETE = 3'd1,
        REQ_EXPIRE   = 3'd2,
        REQ_DISP_HD  = 3'd3,
        REQ_DISP_NM  = 3'd4,
        REQ_CHARGE   = 3'd5,
        REQ_LOOKUP   = 3'd6,
        REQ_BAD      = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_RUNNING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Queue cell command: rotate the whole row by one place, or hold.
    typedef struct packed {
        logic shift;
    } t_qctl;

endpackage

// File: hdl/fjrq_qcell.sv
// ----------------------------------------------------------------------------
// fjrq_qcell
// One ready queue cell. Holds an id and a work snapshot, and either loads,
// takes its right neighbor's word, or holds.
// ----------------------------------------------------------------------------
module fjrq_qcell #(
    parameter int ID_BITS = fjrq_pkg::IdBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_load,
    input  logic [ID_BITS-1:0]            i_nb_id,
    input  logic [fjrq_pkg::WordBits-1:0] i_nb_work,
    input  logic [ID_BITS-1:0]            i_ld_id,
    input  logic [fjrq_pkg::WordBits-1:0] i_ld_work,
    output logic [ID_BITS-1:0]            o_id,
    output logic [fjrq_pkg::WordBits-1:0] o_work
);
    import fjrq_pkg::*;

    logic [ID_BITS-1:0]  r_id;
    logic [WordBits-1:0] r_work;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id   <= i_ld_id;
            r_work <= i_ld_work;
        end else if (i_shift) begin
            r_id   <= i_nb_id;
            r_work <= i_nb_work;
        end
    end

    assign o_id   = r_id;
    assign o_work = r_work;
endmodule

// File: hdl/fjrq_tcell.sv
// ----------------------------------------------------------------------------
// fjrq_tcell
// One job table cell: valid flag, id, remaining work and last run time.
// ----------------------------------------------------------------------------
module fjrq_tcell #(
    parameter int ID_BITS = fjrq_pkg::IdBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_set,
    input  logic                          i_clr,
    input  logic                          i_wr_work,
    input  logic                          i_wr_last,
    input  logic [ID_BITS-1:0]            i_id,
    input  logic [fjrq_pkg::WordBits-1:0] i_work,
    input  logic [fjrq_pkg::WordBits-1:0] i_last,
    output logic                          o_valid,
    output logic [ID_BITS-1:0]            o_id,
    output logic [fjrq_pkg::WordBits-1:0] o_work,
    output logic [fjrq_pkg::WordBits-1:0] o_last
);
    import fjrq_pkg::*;

    logic                r_valid;
    logic [ID_BITS-1:0]  r_id;
    logic [WordBits-1:0] r_work;
    logic [WordBits-1:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_set) begin
            r_valid <= 1'b1;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_set) begin
            r_id <= i_id;
        end
        if (i_wr_work) begin
            r_work <= i_work;
        end
        if (i_wr_last) begin
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_work  = r_work;
    assign o_last  = r_last;
endmodule

// File: hdl/fifo_job_run_queue_top.sv
// ----------------------------------------------------------------------------
// fifo_job_run_queue_top
// FIFO run queue scheduler with a job table and an ordered ready queue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result word is shown on o_strobe for one cycle. The next
// request can be taken while the result word is shown. The table is
// scanned one slot a cycle for the matching and the first free slot, then
// the ready queue cells rotate one place a cycle while the element position
// is searched, and the S_DONE state applies the update and forms the result.
// The receiver cannot stall.
module fifo_job_run_queue_top #(
    parameter int MAX_JOBS = fjrq_pkg::MaxJobsDefault,
    parameter int ID_BITS  = fjrq_pkg::IdBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fjrq_pkg::WordBits-1:0] i_cfg_data,
    input  logic [2:0]                    i_req_type,
    input  logic [ID_BITS-1:0]            i_job_id,
    input  logic [fjrq_pkg::WordBits-1:0] i_amount,
    input  logic [fjrq_pkg::WordBits-1:0] i_now_time,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [ID_BITS-1:0]            o_out_job_id,
    output logic [fjrq_pkg::WordBits-1:0] o_grant_time,
    output logic [fjrq_pkg::WordBits-1:0] o_work_left,
    output logic [fjrq_pkg::WordBits-1:0] o_last_run,
    output logic                          o_job_done,
    output logic [4:0]                    o_queue_count,
    output logic [ID_BITS-1:0]            o_running_id
);
    import fjrq_pkg::*;

    localparam int SW = $clog2(MAX_JOBS);
    localparam int LW = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_QWALK, S_DONE} t_state;

    t_state              r_state;
    logic [SW:0]         r_cnt;
    t_req                r_req;
    logic [ID_BITS-1:0]  r_id;
    logic [WordBits-1:0] r_amt;
    logic [WordBits-1:0] r_now;
    logic [WordBits-1:0] r_slice;
    logic [LW-1:0]       r_len;
    logic [ID_BITS-1:0]  r_cur;
    logic                r_hit;
    logic [SW-1:0]       r_hslot;
    logic                r_free;
    logic [SW-1:0]       r_fslot;
    logic                r_qhit;
    logic [LW-1:0]       r_qpos;
    logic [ID_BITS-1:0]  r_qid;
    logic [WordBits-1:0] r_qwork;
    logic                r_strobe;
    logic [1:0]          r_status;
    logic [ID_BITS-1:0]  r_oid;
    logic [WordBits-1:0] r_grant;
    logic [WordBits-1:0] r_wleft;
    logic [WordBits-1:0] r_lrun;
    logic                r_done;

    logic [MAX_JOBS-1:0] t_valid;
    logic [ID_BITS-1:0]  t_id   [MAX_JOBS];
    logic [WordBits-1:0] t_work [MAX_JOBS];
    logic [WordBits-1:0] t_last [MAX_JOBS];
    logic [MAX_JOBS-1:0] t_set, t_clr, t_ww, t_wl;
    logic [WordBits-1:0] n_twork, n_tlast;

    logic [ID_BITS-1:0]  q_id   [MAX_JOBS];
    logic [WordBits-1:0] q_work [MAX_JOBS];
    logic [MAX_JOBS-1:0] q_shift, q_load;
    logic [ID_BITS-1:0]  n_ldid;
    logic [WordBits-1:0] n_ldwork;
    t_qctl               qctl;

    logic [SW-1:0]       scan_i;
    logic [SW-1:0]       slot;
    logic                slot_ok;
    logic [WordBits-1:0] sw_work;
    logic [WordBits-1:0] charged;
    logic [WordBits-1:0] snap;
    logic                push;
    logic [LW-1:0]       n_len;
    logic [ID_BITS-1:0]  n_cur;
    logic [1:0]          n_status;
    logic [ID_BITS-1:0]  n_oid;
    logic [WordBits-1:0] n_grant;
    logic                n_done;
    logic                n_keep;
    logic                qwalk_end;

    assign scan_i = r_cnt[SW-1:0];

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cells
            fjrq_tcell #(.ID_BITS(ID_BITS)) u_t (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_set(t_set[g]), .i_clr(t_clr[g]),
                .i_wr_work(t_ww[g]), .i_wr_last(t_wl[g]),
                .i_id(r_id), .i_work(n_twork), .i_last(n_tlast),
                .o_valid(t_valid[g]), .o_id(t_id[g]),
                .o_work(t_work[g]), .o_last(t_last[g])
            );
            // Queue cells rotate: cell g takes cell g+1, the last takes cell 0.
            fjrq_qcell #(.ID_BITS(ID_BITS)) u_q (
                .i_clk(i_clk),
                .i_shift(q_shift[g]), .i_load(q_load[g]),
                .i_nb_id(q_id[(g + 1) % MAX_JOBS]),
                .i_nb_work(q_work[(g + 1) % MAX_JOBS]),
                .i_ld_id(n_ldid), .i_ld_work(n_ldwork),
                .o_id(q_id[g]), .o_work(q_work[g])
            );
        end
    endgenerate

    // The queue walk rotates the whole row MAX_JOBS times, so it ends where
    // it started; the element in cell 0 is inspected each cycle. Removal
    // is done in the S_DONE state by shifting cells from the found position.
    assign qwalk_end = (r_cnt == (SW + 1)'(MAX_JOBS - 1));
    assign qctl.shift = (r_state == S_QWALK);

    assign slot    = r_hit ? r_hslot : r_fslot;
    assign slot_ok = r_hit || (r_free && r_req == REQ_ARRIVE);
    assign sw_work = t_work[slot];
    assign charged = (sw_work > r_amt) ? sw_work - r_amt : '0;

    always_comb begin
        t_set = '0; t_clr = '0; t_ww = '0; t_wl = '0;
        q_shift = '0; q_load = '0;
        n_twork = r_amt; n_tlast = r_now;
        n_ldid = r_id; n_ldwork = r_amt;
        snap = r_amt; push = 1'b0;
        n_len = r_len; n_cur = r_cur;
        n_status = ST_NONE; n_oid = '0; n_grant = '0; n_done = 1'b0;
        n_keep = 1'b0;
        if (qctl.shift) begin
            q_shift = '1;
        end
        if (r_state == S_DONE) begin
            unique case (r_req)
                REQ_ARRIVE: begin
                    if (r_id != '0) begin
                        if (!r_hit && !r_free) begin
                            n_status = ST_FULL;
                        end else begin
                            t_set[slot] = !r_hit;
                            t_ww[slot] = 1'b1;
                            t_wl[slot] = 1'b1;
                            push = !r_qhit;
                            n_status = ST_OK;
                            n_keep = 1'b1;
                        end
                    end
                end
                REQ_COMPLETE: begin
                    if (r_cur == r_id) begin
                        n_cur = '0;
                    end
                    if (r_hit) begin
                        t_clr[slot] = 1'b1;
                    end
                    n_status = (r_hit || r_qhit) ? ST_OK : ST_NONE;
                end
                REQ_EXPIRE: begin
                    if (r_hit && r_cur == r_id) begin
                        t_wl[slot] = 1'b1;
                        n_cur = '0;
                        snap = sw_work;
                        push = !r_qhit;
                        n_status = ST_OK;
                        n_keep = 1'b1;
                    end
                end
                REQ_DISP_HD, REQ_DISP_NM: begin
                    if (r_cur != '0) begin
                        n_status = ST_RUNNING;
                    end else if (r_qhit) begin
                        n_cur = r_qid;
                        if (r_hit) begin
                            t_wl[slot] = 1'b1;
                            n_grant = (r_slice < r_qwork) ? r_slice : r_qwork;
                            n_oid = r_qid;
                            n_status = ST_OK;
                            n_keep = 1'b1;
                        end
                    end
                end
                REQ_CHARGE: begin
                    if (r_hit) begin
                        t_ww[slot] = 1'b1;
                        n_twork = charged;
                        if (charged == '0) begin
                            n_done = 1'b1;
                            n_cur = '0;
                        end
                        n_status = ST_OK;
                        n_keep = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (r_hit) begin
                        n_oid = r_id;
                        n_status = ST_OK;
                        n_keep = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // Removal from the queue closes the gap by one shift.
            if (r_qhit && (r_req == REQ_COMPLETE ||
                    ((r_req == REQ_DISP_HD || r_req == REQ_DISP_NM) && r_cur == '0))) begin
                for (int k = 0; k < MAX_JOBS; k++) begin
                    if (LW'(k) >= r_qpos && LW'(k + 1) < r_len) begin
                        q_shift[k] = 1'b1;
                    end
                end
                n_len = r_len - LW'(1);
            end
            if (push && r_len < LW'(MAX_JOBS)) begin
                n_ldwork = snap;
                q_load[r_len[SW-1:0]] = 1'b1;
                n_len = r_len + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cur    <= '0;
            r_slice  <= SliceReset;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slice <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= t_req'(i_req_type);
                        r_id    <= (t_req'(i_req_type) == REQ_DISP_HD) ? q_id[0] : i_job_id;
                        r_amt   <= i_amount;
                        r_now   <= i_now_time;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_qhit  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (t_valid[scan_i] && t_id[scan_i] == r_id && !r_hit) begin
                        r_hit   <= 1'b1;
                        r_hslot <= scan_i;
                    end
                    if (!t_valid[scan_i] && !r_free) begin
                        r_free  <= 1'b1;
                        r_fslot <= scan_i;
                    end
                    if (r_cnt == (SW + 1)'(MAX_JOBS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_QWALK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_QWALK: begin
                    if (!r_qhit && LW'(r_cnt) < r_len &&
                            ((r_req == REQ_DISP_HD) || q_id[0] == r_id)) begin
                        r_qhit  <= 1'b1;
                        r_qpos  <= LW'(r_cnt);
                        r_qid   <= q_id[0];
                        r_qwork <= q_work[0];
                    end
                    if (qwalk_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    r_len    <= n_len;
                    r_cur    <= n_cur;
                    r_strobe <= 1'b1;
                    r_status <= n_status;
                    r_oid    <= n_oid;
                    r_grant  <= n_grant;
                    r_done   <= n_done;
                    r_wleft  <= n_keep ? (r_req == REQ_CHARGE ? charged :
                                (r_req == REQ_ARRIVE ? r_amt : sw_work)) : '0;
                    r_lrun   <= n_keep ? ((r_req == REQ_CHARGE || r_req == REQ_LOOKUP) ?
                                t_last[slot] : r_now) : '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Head dispatch uses the slot of the queued id; scan with that id.
    // The scan runs before the walk, so a head dispatch resolves the table
    // entry by matching the head id, loaded into r_id at acceptance time.

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_job_id  = r_oid;
    assign o_grant_time  = r_grant;
    assign o_work_left   = r_wleft;
    assign o_last_run    = r_lrun;
    assign o_job_done    = r_done;
    assign o_queue_count = 5'(r_len);
    assign o_running_id  = r_cur;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the FIFO job run queue scheduler. A behavioral copy of
// the job table and ready queue predicts every result word, which a monitor
// compares field by field as each strobe arrives.
// ----------------------------------------------------------------------------
module testbench;
    import fjrq_pkg::*;

    localparam int NJobs = 16;
    localparam int WatchLimit = 20000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] out_id;
        logic [31:0] grant;
        logic [31:0] work;
        logic [31:0] last;
        logic        done;
        logic [4:0]  qcount;
        logic [31:0] running;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic [2:0]  i_req_type;
    logic [31:0] i_job_id;
    logic [31:0] i_amount;
    logic [31:0] i_now_time;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_out_job_id;
    logic [31:0] o_grant_time;
    logic [31:0] o_work_left;
    logic [31:0] o_last_run;
    logic        o_job_done;
    logic [4:0]  o_queue_count;
    logic [31:0] o_running_id;

    fifo_job_run_queue_top u_top (.*);

    // Scheduler state held by the predictor.
    logic        tbl_valid [NJobs];
    logic [31:0] tbl_id    [NJobs];
    logic [31:0] tbl_work  [NJobs];
    logic [31:0] tbl_last  [NJobs];
    logic [31:0] rq_id     [$];
    logic [31:0] rq_work   [$];
    logic [31:0] run_job;
    logic [31:0] slice;

    t_word       expected_words [$];
    int          errors;
    int          words_seen;
    int          idle_cycles;
    int          send_idle_pct;
    int          n_sent;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int table_find(logic [31:0] id);
        for (int i = 0; i < NJobs; i++)
            if (tbl_valid[i] && tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int queue_find(logic [31:0] id);
        for (int i = 0; i < rq_id.size(); i++)
            if (rq_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void queue_append(logic [31:0] id, logic [31:0] w);
        if (queue_find(id) < 0 && rq_id.size() < NJobs) begin
            rq_id.insert(rq_id.size(), id);
            rq_work.insert(rq_work.size(), w);
        end
    endfunction

    function automatic t_word schedule(t_req req, logic [31:0] id, logic [31:0] amt,
                                       logic [31:0] now);
        t_word r;
        int s;
        int q;
        s = -1;
        r = '{ST_NONE, 0, 0, 0, 0, 0, 0, 0};
        case (req)
            REQ_ARRIVE: begin
                if (id != 0) begin
                    s = table_find(id);
                    if (s < 0) begin
                        for (int i = 0; i < NJobs; i++)
                            if (!tbl_valid[i] && s < 0) s = i;
                        if (s >= 0) begin
                            tbl_valid[s] = 1'b1;
                            tbl_id[s] = id;
                        end
                    end
                    if (s < 0) r.status = ST_FULL;
                    else begin
                        tbl_work[s] = amt;
                        tbl_last[s] = now;
                        queue_append(id, amt);
                        r.status = ST_OK;
                    end
                end
            end
            REQ_COMPLETE: begin
                if (run_job == id) run_job = 0;
                s = table_find(id);
                q = queue_find(id);
                if (s >= 0) tbl_valid[s] = 1'b0;
                if (q >= 0) begin
                    rq_id.delete(q);
                    rq_work.delete(q);
                end
                if (s >= 0 || q >= 0) r.status = ST_OK;
            end
            REQ_EXPIRE: begin
                s = table_find(id);
                if (s < 0 || run_job != id) s = -1;
                else begin
                    tbl_last[s] = now;
                    run_job = 0;
                    queue_append(id, tbl_work[s]);
                    r.status = ST_OK;
                end
            end
            REQ_DISP_HD, REQ_DISP_NM: begin
                if (run_job != 0) r.status = ST_RUNNING;
                else begin
                    q = (req == REQ_DISP_HD) ? (rq_id.size() > 0 ? 0 : -1) : queue_find(id);
                    if (q >= 0) begin
                        logic [31:0] qid;
                        logic [31:0] qw;
                        qid = rq_id[q];
                        qw = rq_work[q];
                        rq_id.delete(q);
                        rq_work.delete(q);
                        run_job = qid;
                        s = table_find(qid);
                        if (s >= 0) begin
                            tbl_last[s] = now;
                            r.grant = slice < qw ? slice : qw;
                            r.out_id = qid;
                            r.status = ST_OK;
                        end
                    end
                end
            end
            REQ_CHARGE: begin
                s = table_find(id);
                if (s >= 0) begin
                    tbl_work[s] = tbl_work[s] > amt ? tbl_work[s] - amt : 0;
                    if (tbl_work[s] == 0) begin
                        r.done = 1'b1;
                        run_job = 0;
                    end
                    r.status = ST_OK;
                end
            end
            REQ_LOOKUP: begin
                s = table_find(id);
                if (s >= 0) begin
                    r.out_id = id;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        if (r.status == ST_OK && s >= 0 && tbl_valid[s]) begin
            r.work = tbl_work[s];
            r.last = tbl_last[s];
        end
        r.qcount = 5'(rq_id.size());
        r.running = run_job;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("MISMATCH word %0d %s: got %h, expected %h", words_seen, what, got, exp);
        errors++;
    endtask

    // Monitor of result words.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_word e;
            words_seen++;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, status", 32'(o_status), 32'd0);
            end else begin
                e = expected_words[0];
                expected_words.delete(0);
                if (o_status !== e.status)
                    report_mismatch("status", 32'(o_status), 32'(e.status));
                if (o_out_job_id !== e.out_id) report_mismatch("job id", o_out_job_id, e.out_id);
                if (o_grant_time !== e.grant) report_mismatch("grant", o_grant_time, e.grant);
                if (o_work_left !== e.work) report_mismatch("work", o_work_left, e.work);
                if (o_last_run !== e.last) report_mismatch("last run", o_last_run, e.last);
                if (o_job_done !== e.done)
                    report_mismatch("done", 32'(o_job_done), 32'(e.done));
                if (o_queue_count !== e.qcount)
                    report_mismatch("queue count", 32'(o_queue_count), 32'(e.qcount));
                if (o_running_id !== e.running)
                    report_mismatch("running", o_running_id, e.running);
            end
        end
    end

    // Watchdog on cycles without accepted traffic.
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("timeout waiting on the scheduler");
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_request(t_req req, logic [31:0] id, logic [31:0] amt,
                                logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_job_id <= id;
        i_amount <= amt;
        i_now_time <= now;
        do @(posedge i_clk); while (busy);
        expected_words.insert(expected_words.size(), schedule(req, id, amt, now));
        n_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        slice = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_request(REQ_DISP_HD, 0, 0, 0);
        send_request(REQ_ARRIVE, 0, 5, 5);
        send_request(REQ_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ARRIVE, 1, 50, 3);
        send_request(REQ_ARRIVE, 1, 500, 4);
        send_request(REQ_DISP_HD, 0, 0, 10);
        send_request(REQ_DISP_NM, 1, 0, 11);
        send_request(REQ_CHARGE, 32'hFFFF_FFFF, 1, 0);
        send_request(REQ_EXPIRE, 32'hFFFF_FFFF, 0, 20);
        send_request(REQ_DISP_NM, 7, 0, 21);
        send_request(REQ_DISP_NM, 1, 0, 22);
        send_request(REQ_CHARGE, 1, 32'hFFFF_FFFF, 23);
        send_request(REQ_LOOKUP, 1, 0, 0);
        send_request(REQ_LOOKUP, 9, 0, 0);
        send_request(REQ_COMPLETE, 1, 0, 0);
        send_request(REQ_COMPLETE, 1, 0, 0);
        send_request(REQ_BAD, 1, 0, 0);
        for (int i = 2; i < 20; i++) send_request(REQ_ARRIVE, i, i, i);
    endtask

    task automatic test_random(int count, int pct);
        send_idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            logic [31:0] id;
            logic [31:0] amt;
            t_req req;
            id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20);
            amt = ($urandom_range(7) == 0) ? $urandom : $urandom_range(300);
            case ($urandom_range(11))
                0, 1, 2: req = REQ_ARRIVE;
                3: req = REQ_COMPLETE;
                4: req = REQ_EXPIRE;
                5, 6: req = REQ_DISP_HD;
                7: req = REQ_DISP_NM;
                8, 9: req = REQ_CHARGE;
                10: req = REQ_LOOKUP;
                default: req = t_req'($urandom_range(7));
            endcase
            if (req == REQ_EXPIRE && $urandom_range(1)) id = run_job;
            if (req == REQ_CHARGE && $urandom_range(1)) id = run_job;
            send_request(req, id, amt, $urandom);
        end
        send_idle_pct = 0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_req_type = '0;
        i_job_id = '0;
        i_amount = '0;
        i_now_time = '0;
        errors = 0;
        words_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        n_sent = 0;
        run_job = 0;
        slice = SliceReset;
        for (int i = 0; i < NJobs; i++) tbl_valid[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_slice(32'd1);
        test_random(300, 0);
        write_slice(32'hFFFF_FFFF);
        test_random(400, 74);
        write_slice(32'd40);
        test_random(400, 0);
        write_slice(32'h8000_0001);
        test_random(400, 15);
        drain();

        $display("Sent %0d requests and checked %0d result words over four slice settings.",
                 n_sent, words_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
